[hw/rtl/pibrl_pkg.sv]
// Package for the point-in-box region lookup: sizes, operation codes, states,
// item, result, point and box types. No dependencies.
package pibrl_pkg;

  localparam int MAX_REGIONS = 64;
  localparam int COORD_WIDTH = 16;
  localparam int MARGIN_W    = 10;
  localparam int OP_W        = 2;
  localparam int RIDX_W      = 6;
  localparam int STORED_W    = 7;

  localparam int IDX_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
  localparam int BOX_CW = (COORD_WIDTH + 1 > MARGIN_W + 2) ? COORD_WIDTH + 1 : MARGIN_W + 2;
  localparam int BOX_W  = 6 * BOX_CW;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(256);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]               operation;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
  } item_t;

  typedef struct packed {
    logic                found;
    logic [RIDX_W-1:0]   region_index;
    logic                dropped;
    logic [STORED_W-1:0] stored_count;
  } result_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [BOX_CW-1:0] lo_x;
    logic signed [BOX_CW-1:0] lo_y;
    logic signed [BOX_CW-1:0] lo_z;
    logic signed [BOX_CW-1:0] hi_x;
    logic signed [BOX_CW-1:0] hi_y;
    logic signed [BOX_CW-1:0] hi_z;
  } box_t;

endpackage

[hw/rtl/pibrl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pibrl_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/pibrl_box_prep.sv]
// Corner ordering and vertical widening of a box to be stored.
// Depends on pibrl_pkg.
module pibrl_box_prep (
  input  pibrl_pkg::item_t                    item_i,
  input  logic [pibrl_pkg::MARGIN_W-1:0]      margin_i,
  output pibrl_pkg::box_t                     box_o
);
  import pibrl_pkg::*;

  logic signed [BOX_CW-1:0] ax, ay, az, bx, by, bz, marg;

  always_comb begin
    ax   = BOX_CW'(item_i.first_x);
    ay   = BOX_CW'(item_i.first_y);
    az   = BOX_CW'(item_i.first_z);
    bx   = BOX_CW'(item_i.second_x);
    by   = BOX_CW'(item_i.second_y);
    bz   = BOX_CW'(item_i.second_z);
    marg = BOX_CW'($signed({1'b0, margin_i}));

    box_o.lo_x = (ax > bx) ? bx : ax;
    box_o.hi_x = (ax > bx) ? ax : bx;
    box_o.lo_y = (ay > by) ? by : ay;
    box_o.hi_y = (ay > by) ? ay : by;
    box_o.lo_z = ((az > bz) ? bz : az) - marg;
    box_o.hi_z = ((az > bz) ? az : bz) + marg;
  end

endmodule

[hw/rtl/pibrl_hit.sv]
// Inclusive containment test of a point against one stored box.
// Depends on pibrl_pkg.
module pibrl_hit (
  input  pibrl_pkg::point_t point_i,
  input  pibrl_pkg::box_t   box_i,
  output logic              hit_o
);
  import pibrl_pkg::*;

  logic signed [BOX_CW-1:0] px, py, pz;

  always_comb begin
    px    = BOX_CW'(point_i.x);
    py    = BOX_CW'(point_i.y);
    pz    = BOX_CW'(point_i.z);
    hit_o = (px >= box_i.lo_x) && (px <= box_i.hi_x) &&
            (py >= box_i.lo_y) && (py <= box_i.hi_y) &&
            (pz >= box_i.lo_z) && (pz <= box_i.hi_z);
  end

endmodule

[hw/rtl/point_in_box_region_lookup.sv]
// Top level of the point-in-box region lookup: box table RAM, scan control.
// Depends on pibrl_pkg, pibrl_ram, pibrl_box_prep, pibrl_hit.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+------------------------
//   item in   | start / busy              | item_i  (item_t)
//   result    | res_valid_o, one cycle    | res_o   (result_t)
//   config    | cfg_valid_i / cfg_ready_o | cfg_data_i (z_margin)
//
// Clear, add and unused codes finish at the accepting edge; the result shows
// in the next cycle and busy stays low. A query scans the RAM one entry per
// cycle, reads pipelined with compares; the scan ends at the first hit, or
// on a miss once the last stored entry has been compared.
// Reset empties the table and sets z_margin to 256. The result is not held.
module point_in_box_region_lookup (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  pibrl_pkg::item_t                item_i,
  output logic                            res_valid_o,
  output pibrl_pkg::result_t              res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pibrl_pkg::MARGIN_W-1:0]  cfg_data_i
);
  import pibrl_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    rd_idx_q, rd_idx_d;
  logic                pend_q, pend_d;
  logic [IDX_W-1:0]    pend_idx_q, pend_idx_d;
  point_t              pt_q, pt_d;
  logic [MARGIN_W-1:0] margin_q;
  logic                res_valid_q, res_valid_d;
  result_t             res_q, res_d;

  logic   accept, full, issue, hit, we;
  box_t   new_box, rd_box;

  assign busy        = (state_q == ST_SCAN);
  assign cfg_ready_o = !busy;
  assign accept      = start && !busy;
  assign full        = (count_q >= CNT_W'(MAX_REGIONS));
  assign issue       = (state_q == ST_SCAN) && (rd_idx_q < count_q);

  pibrl_box_prep u_prep (
    .item_i   (item_i),
    .margin_i (margin_q),
    .box_o    (new_box)
  );

  pibrl_ram #(
    .Width (BOX_W),
    .Depth (MAX_REGIONS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (new_box),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rd_box)
  );

  pibrl_hit u_hit (
    .point_i (pt_q),
    .box_i   (rd_box),
    .hit_o   (hit)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    pt_d        = pt_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    we          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d = '0;
          case (item_i.operation)
            OP_CLEAR: begin
              count_d     = '0;
              res_valid_d = 1'b1;
            end
            OP_ADD: begin
              if (full) begin
                res_d.dropped = 1'b1;
              end else begin
                we      = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
              res_valid_d = 1'b1;
            end
            OP_QUERY: begin
              state_d  = ST_SCAN;
              rd_idx_d = '0;
              pend_d   = 1'b0;
              pt_d     = '{x: item_i.first_x, y: item_i.first_y, z: item_i.first_z};
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
          res_d.stored_count = STORED_W'(count_d);
        end
      end
      ST_SCAN: begin
        pend_d     = issue;
        pend_idx_d = rd_idx_q[IDX_W-1:0];
        if (issue) begin
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end
        res_d              = '0;
        res_d.stored_count = STORED_W'(count_q);
        if (pend_q && hit) begin
          state_d            = ST_IDLE;
          pend_d             = 1'b0;
          res_d.found        = 1'b1;
          res_d.region_index = RIDX_W'(pend_idx_q);
          res_valid_d        = 1'b1;
        end else if (!issue) begin
          state_d     = ST_IDLE;
          pend_d      = 1'b0;
          res_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
      margin_q    <= MARGIN_RESET;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        margin_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    pt_q       <= pt_d;
    res_q      <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_REGIONS))
    else $error("region count above table size");

  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.found |-> (CNT_W'(res_o.region_index) < count_q))
    else $error("found index beyond stored count");

  a_found_xor_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_o.found && res_o.dropped))
    else $error("result both found and dropped");

  a_scan_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && item_i.operation == OP_QUERY))
    else $error("scan started without a query item");

endmodule

[test/tb_point_in_box_region_lookup.sv]
// Testbench for point_in_box_region_lookup: directed and random clear, add, query
// and unused-code items, checked against a behavioral model of the box table.
// Depends on pibrl_pkg and the point_in_box_region_lookup RTL.
module tb_point_in_box_region_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import pibrl_pkg::*;

  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int REPORT_LIMIT = 40;
  localparam int WINDOW       = 400;
  localparam int COORD_MIN    = -(2 ** (COORD_WIDTH - 1));
  localparam int COORD_MAX    = 2 ** (COORD_WIDTH - 1) - 1;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  item_t               item_i;
  logic                res_valid_o;
  result_t             res_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [MARGIN_W-1:0] cfg_data_i;

  box_t                region_boxes [MAX_REGIONS];
  int                  box_count;
  logic [MARGIN_W-1:0] z_margin;
  result_t             expected_results [$];
  int                  error_count;
  int                  cycle_count = 0;

  always #5ns clk_i = ~clk_i;

  point_in_box_region_lookup dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  function automatic void box_bounds(input box_t bx, output int lo[3], output int hi[3]);
    lo[0] = $signed(bx.lo_x);
    lo[1] = $signed(bx.lo_y);
    lo[2] = $signed(bx.lo_z);
    hi[0] = $signed(bx.hi_x);
    hi[1] = $signed(bx.hi_y);
    hi[2] = $signed(bx.hi_z);
  endfunction

  function automatic result_t lookup_expected(item_t it);
    int      a[3];
    int      b[3];
    int      lo[3];
    int      hi[3];
    bit      hit;
    result_t res;
    res  = '0;
    a[0] = $signed(it.first_x);
    a[1] = $signed(it.first_y);
    a[2] = $signed(it.first_z);
    b[0] = $signed(it.second_x);
    b[1] = $signed(it.second_y);
    b[2] = $signed(it.second_z);
    case (it.operation)
      OP_CLEAR: box_count = 0;
      OP_ADD: begin
        if (box_count >= MAX_REGIONS) begin
          res.dropped = 1'b1;
        end else begin
          for (int k = 0; k < 3; k++) begin
            lo[k] = (a[k] > b[k]) ? b[k] : a[k];
            hi[k] = (a[k] > b[k]) ? a[k] : b[k];
          end
          lo[2] -= int'(z_margin);
          hi[2] += int'(z_margin);
          region_boxes[box_count] = '{lo_x: BOX_CW'(lo[0]), lo_y: BOX_CW'(lo[1]),
                                      lo_z: BOX_CW'(lo[2]), hi_x: BOX_CW'(hi[0]),
                                      hi_y: BOX_CW'(hi[1]), hi_z: BOX_CW'(hi[2])};
          box_count++;
        end
      end
      OP_QUERY: begin
        for (int i = 0; i < box_count; i++) begin
          box_bounds(region_boxes[i], lo, hi);
          hit = 1'b1;
          for (int k = 0; k < 3; k++) begin
            if (a[k] < lo[k] || a[k] > hi[k]) hit = 1'b0;
          end
          if (hit) begin
            res.found        = 1'b1;
            res.region_index = RIDX_W'(i);
            break;
          end
        end
      end
      default: ;
    endcase
    res.stored_count = STORED_W'(box_count);
    return res;
  endfunction

  function automatic item_t make_item(logic [OP_W-1:0] op, int fx, int fy, int fz,
                                      int sx, int sy, int sz);
    item_t it;
    it.operation = op;
    it.first_x   = COORD_WIDTH'(fx);
    it.first_y   = COORD_WIDTH'(fy);
    it.first_z   = COORD_WIDTH'(fz);
    it.second_x  = COORD_WIDTH'(sx);
    it.second_y  = COORD_WIDTH'(sy);
    it.second_z  = COORD_WIDTH'(sz);
    return it;
  endfunction

  function automatic int rand_coord();
    logic signed [COORD_WIDTH-1:0] v;
    v = COORD_WIDTH'($urandom);
    return v;
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp_coord(int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic item_t random_box();
    int a[3];
    int b[3];
    int c;
    int t;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(9) < 8) begin
        c = rand_between(-WINDOW, WINDOW);
        if ($urandom_range(9) == 0) begin
          a[k] = c;
          b[k] = c;
        end else begin
          a[k] = c - int'($urandom_range(120));
          b[k] = c + int'($urandom_range(120));
        end
      end else begin
        a[k] = rand_coord();
        b[k] = rand_coord();
      end
      if ($urandom_range(1) == 1) begin
        t    = a[k];
        a[k] = b[k];
        b[k] = t;
      end
    end
    return make_item(OP_ADD, a[0], a[1], a[2], b[0], b[1], b[2]);
  endfunction

  function automatic item_t random_query();
    int lo[3];
    int hi[3];
    int p[3];
    int r;
    r = $urandom_range(99);
    if (box_count > 0 && r < 55) begin
      box_bounds(region_boxes[$urandom_range(box_count - 1)], lo, hi);
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(9))
          0:       p[k] = lo[k];
          1:       p[k] = hi[k];
          2:       p[k] = lo[k] - 1;
          3:       p[k] = hi[k] + 1;
          default: p[k] = rand_between(clamp_coord(lo[k]), clamp_coord(hi[k]));
        endcase
        p[k] = clamp_coord(p[k]);
      end
    end else if (r < 85) begin
      for (int k = 0; k < 3; k++) p[k] = rand_between(-WINDOW - 150, WINDOW + 150);
    end else begin
      for (int k = 0; k < 3; k++) p[k] = rand_coord();
    end
    return make_item(OP_QUERY, p[0], p[1], p[2], rand_coord(), rand_coord(), rand_coord());
  endfunction

  function automatic void compare_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endfunction

  task automatic send_item(item_t it);
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    expected_results.push_back(lookup_expected(it));
  endtask

  task automatic idle_gap(int pct);
    int n;
    n = 0;
    while (int'($urandom_range(99)) < pct) n++;
    if (n > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_z_margin(logic [MARGIN_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    z_margin = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_empty_table();
    send_item(make_item(OP_QUERY, -1, -1, -1, COORD_MAX, COORD_MIN, 0));
    send_item(make_item(OP_NOP, COORD_MAX, -1, COORD_MIN, -1, COORD_MAX, COORD_MIN));
  endtask

  task automatic test_bounds_and_degenerate();
    send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_ADD, 5, -7, 3, 5, -7, 3));
    send_item(make_item(OP_QUERY, 5, -7, 3, 0, 0, 0));
    send_item(make_item(OP_QUERY, 6, -7, 3, 0, 0, 0));
    send_item(make_item(OP_QUERY, 5, -7, 259, 0, 0, 0));
    send_item(make_item(OP_QUERY, 5, -7, 260, 0, 0, 0));
    send_item(make_item(OP_QUERY, 5, -7, -253, 0, 0, 0));
    send_item(make_item(OP_ADD, COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MIN, COORD_MIN, COORD_MIN));
    send_item(make_item(OP_QUERY, 6, -7, 3, 0, 0, 0));
    send_item(make_item(OP_QUERY, COORD_MIN, COORD_MIN, COORD_MIN, -1, -1, -1));
    send_item(make_item(OP_QUERY, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0));
    send_item(make_item(OP_NOP, rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord()));
    send_item(make_item(OP_CLEAR, COORD_MAX, COORD_MIN, -1, -1, COORD_MIN, COORD_MAX));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_margin_extremes();
    write_z_margin(10'd1023);
    send_item(make_item(OP_ADD, 0, 0, COORD_MIN, 0, 0, COORD_MIN));
    send_item(make_item(OP_QUERY, 0, 0, COORD_MIN, 0, 0, 0));
    send_item(make_item(OP_ADD, 20, 20, COORD_MAX, 10, 10, COORD_MAX));
    send_item(make_item(OP_QUERY, 15, 15, COORD_MAX, 0, 0, 0));
    send_item(make_item(OP_QUERY, 0, 0, -31745, 0, 0, 0));
    send_item(make_item(OP_QUERY, 0, 0, -31744, 0, 0, 0));
    write_z_margin(10'd0);
    send_item(make_item(OP_ADD, 100, 100, 100, 90, 110, 100));
    send_item(make_item(OP_QUERY, 95, 105, 100, 0, 0, 0));
    send_item(make_item(OP_QUERY, 95, 105, 101, 0, 0, 0));
  endtask

  task automatic run_random(int n_items, int idle_pct);
    int    sent;
    int    episode;
    int    ep_len;
    int    add_pct;
    int    r;
    bit    big_episode;
    item_t it;
    sent    = 0;
    episode = 0;
    while (sent < n_items) begin
      big_episode = (episode % 4 == 3);
      ep_len      = big_episode ? rand_between(150, 170) : rand_between(8, 50);
      add_pct     = big_episode ? 55 : 40;
      idle_gap(idle_pct);
      send_item(make_item(OP_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord()));
      sent++;
      for (int j = 0; j < ep_len && sent < n_items; j++) begin
        r = $urandom_range(99);
        if (r < 2)
          it = make_item(OP_NOP, rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord());
        else if (r < 2 + add_pct)
          it = random_box();
        else
          it = random_query();
        idle_gap(idle_pct);
        send_item(it);
        sent++;
      end
      episode++;
    end
  endtask

  task automatic test_random_traffic();
    write_z_margin(MARGIN_W'($urandom_range(1022, 1)));
    run_random(640, 0);
    write_z_margin(10'd1023);
    run_random(630, 77);
    write_z_margin(10'd0);
    run_random(630, 15);
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: unexpected result, expected none, actual %p", $time, res_o);
      end else begin
        want = expected_results.pop_front();
        compare_field("found", want.found, res_o.found);
        compare_field("region_index", want.region_index, res_o.region_index);
        compare_field("dropped", want.dropped, res_o.dropped);
        compare_field("stored_count", want.stored_count, res_o.stored_count);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    start       = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    z_margin    = MARGIN_RESET;
    box_count   = 0;
    error_count = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_bounds_and_degenerate();
    test_margin_extremes();
    test_random_traffic();

    drain_results();
    repeat (80) @(posedge clk_i);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pibrl_pkg.sv
hw/rtl/pibrl_ram.sv
hw/rtl/pibrl_box_prep.sv
hw/rtl/pibrl_hit.sv
hw/rtl/point_in_box_region_lookup.sv
test/tb_point_in_box_region_lookup.sv
